/* rtl/nrs_pkg.sv */
`timescale 1ns / 1ps
// nrs_pkg: gold sequence constants, register indexes and generator skip helpers
package nrs_pkg;

	localparam int LFSR_LEN  = 31;
	localparam int GOLD_SKIP = 1600;
	// skip is done in blocks of 32 steps so that no single loop runs long
	localparam int SKIP_BLK  = 32;
	localparam int SKIP_NBLK = GOLD_SKIP / SKIP_BLK;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RNTI          = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCRAMBLING_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODEWORD_IDX  = 2'd2;

	typedef logic [LFSR_LEN-1:0] lfsr_t;
	typedef logic [LFSR_LEN-1:0][LFSR_LEN-1:0] lfsr_mat_t;

	// one step of x1: x1(n+31) = x1(n+3) ^ x1(n)
	function automatic lfsr_t x1_step(input lfsr_t s);
		return {s[0] ^ s[3], s[LFSR_LEN-1:1]};
	endfunction

	// one step of x2: x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n)
	function automatic lfsr_t x2_step(input lfsr_t s);
		return {s[0] ^ s[1] ^ s[2] ^ s[3], s[LFSR_LEN-1:1]};
	endfunction

	function automatic lfsr_t x1_skip(input lfsr_t s);
		lfsr_t r;
		r = s;
		for (int k = 0; k < SKIP_NBLK; k++) begin
			for (int j = 0; j < SKIP_BLK; j++) begin
				r = x1_step(r);
			end
		end
		return r;
	endfunction

	function automatic lfsr_t x2_skip(input lfsr_t s);
		lfsr_t r;
		r = s;
		for (int k = 0; k < SKIP_NBLK; k++) begin
			for (int j = 0; j < SKIP_BLK; j++) begin
				r = x2_step(r);
			end
		end
		return r;
	endfunction

	// x2 skip is linear: column b is the skipped image of seed bit b
	function automatic lfsr_mat_t x2_skip_cols();
		lfsr_mat_t m;
		for (int b = 0; b < LFSR_LEN; b++) begin
			m[b] = x2_skip(lfsr_t'(1) << b);
		end
		return m;
	endfunction

	localparam lfsr_t     X1_START     = x1_skip(lfsr_t'(1));
	localparam lfsr_mat_t X2_SKIP_COLS = x2_skip_cols();

	// x2 state 1600 steps past the seed, as an xor of constant columns
	function automatic lfsr_t x2_start(input lfsr_t seed);
		lfsr_t r;
		r = '0;
		for (int b = 0; b < LFSR_LEN; b++) begin
			if (seed[b]) begin
				r = r ^ X2_SKIP_COLS[b];
			end
		end
		return r;
	endfunction

endpackage

/* rtl/nrs_chan_if.sv */
`timescale 1ns / 1ps
// nrs_chan_if: valid/ready channels for coded words in and scrambled words out
interface nrs_in_if #(
	parameter int WORD_BITS = 32
);
	logic                           valid;
	logic                           ready;
	logic [WORD_BITS-1:0]           coded_bits;
	logic [$clog2(WORD_BITS+1)-1:0] valid_count;
	logic                           first_word;
	logic                           last_word;

	modport source (output valid, output coded_bits, output valid_count,
		output first_word, output last_word, input ready);
	modport sink (input valid, input coded_bits, input valid_count,
		input first_word, input last_word, output ready);
endinterface

interface nrs_out_if #(
	parameter int WORD_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] scrambled_bits;
	logic                 end_of_codeword;

	modport source (output valid, output scrambled_bits, output end_of_codeword,
		input ready);
	modport sink (input valid, input scrambled_bits, input end_of_codeword,
		output ready);
endinterface

/* rtl/nr_pdsch_bit_scrambler.sv */
`timescale 1ns / 1ps
// nr_pdsch_bit_scrambler: gold sequence scrambler for packed codeword bits
//
// din carries one word of coded bits per beat, with its valid bit count and
// first/last word flags; dout carries one scrambled word per input beat, in
// order. a beat with first_word set reloads the generators from the seed
// rnti*2^15 + codeword_index*2^14 + scrambling_id, already skipped 1600 bits,
// and uses the sequence from c(0); every beat consumes WORD_BITS sequence bits.
// the config port (cfg_wr_en, cfg_index, cfg_data) writes rnti, scrambling id
// and codeword index; a new value takes effect at the next first word.
// throughput: one beat per cycle while dout is not held off, set by the unrolled lfsr lookahead that
// produces WORD_BITS sequence bits and the next generator state per cycle.
// path: each input beat passes the input register, then the output register,
// before it leaves as a result beat on dout.
// stall: while dout is held off the output register keeps its word and one
// more beat is taken into the input register; then din.ready drops.
// reset: both pipeline stages empty, config registers and generators zero,
// so words before any first word pass through with only the masking applied.
module nr_pdsch_bit_scrambler #(
	parameter int WORD_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	nrs_in_if.sink                             din,
	nrs_out_if.source                          dout,
	input  logic                               cfg_wr_en,
	input  logic [nrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int LEN   = nrs_pkg::LFSR_LEN;
	localparam int EXT_W = WORD_BITS + LEN;

	// configuration registers
	logic [15:0] rnti_q;
	logic [9:0]  scr_id_q;
	logic        cw_idx_q;

	// generator windows, bit i = x(n+i)
	nrs_pkg::lfsr_t x1_q;
	nrs_pkg::lfsr_t x2_q;

	// input register stage
	logic                 valid_s1;
	logic [WORD_BITS-1:0] coded_s1;
	logic [CNT_W-1:0]     count_s1;
	logic                 first_s1;
	logic                 last_s1;

	// output register stage
	logic                 valid_s2;
	logic [WORD_BITS-1:0] scrambled_s2;
	logic                 eoc_s2;

	logic advance;     // stage 1 may move into stage 2
	logic move_s1;     // a word is processed this cycle
	logic take_in;     // an input beat is accepted

	nrs_pkg::lfsr_t       seed;
	nrs_pkg::lfsr_t       x1_cur;
	nrs_pkg::lfsr_t       x2_cur;
	logic [EXT_W-1:0]     x1_ext;
	logic [EXT_W-1:0]     x2_ext;
	logic [WORD_BITS-1:0] valid_mask;
	logic [WORD_BITS-1:0] scrambled_d;

	// handshake: output register frees when empty or taken
	assign advance = !valid_s2 || dout.ready;
	assign move_s1 = valid_s1 && advance;
	assign din.ready = !valid_s1 || advance;
	assign take_in = din.valid && din.ready;

	// config writes, out of range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnti_q   <= '0;
			scr_id_q <= '0;
			cw_idx_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				nrs_pkg::REG_RNTI:          rnti_q   <= cfg_data[15:0];
				nrs_pkg::REG_SCRAMBLING_ID: scr_id_q <= cfg_data[9:0];
				nrs_pkg::REG_CODEWORD_IDX:  cw_idx_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// seed fields do not overlap, so the sum is a concatenation
	assign seed = {rnti_q[15:0], cw_idx_q, 4'b0000, scr_id_q};

	// first word restarts from the precomputed 1600 bit skip
	assign x1_cur = first_s1 ? nrs_pkg::X1_START : x1_q;
	assign x2_cur = first_s1 ? nrs_pkg::x2_start(seed) : x2_q;

	// lookahead: extend each window by WORD_BITS positions with the recurrences,
	// the xor depth grows only by one level per 28 positions
	always_comb begin
		x1_ext = '0;
		x2_ext = '0;
		x1_ext[LEN-1:0] = x1_cur;
		x2_ext[LEN-1:0] = x2_cur;
		for (int i = LEN; i < EXT_W; i++) begin
			x1_ext[i] = x1_ext[i-31] ^ x1_ext[i-28];
			x2_ext[i] = x2_ext[i-31] ^ x2_ext[i-30] ^ x2_ext[i-29] ^ x2_ext[i-28];
		end
	end

	// bits at and above the valid count come out zero; counts over the word
	// width keep every bit
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			valid_mask[j] = count_s1 > CNT_W'(j);
		end
	end

	assign scrambled_d = (coded_s1 ^ x1_ext[WORD_BITS-1:0] ^ x2_ext[WORD_BITS-1:0])
		& valid_mask;

	// generator state steps once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
		end else if (move_s1) begin
			x1_q <= x1_ext[EXT_W-1:WORD_BITS];
			x2_q <= x2_ext[EXT_W-1:WORD_BITS];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			coded_s1 <= din.coded_bits;
			count_s1 <= din.valid_count;
			first_s1 <= din.first_word;
			last_s1  <= din.last_word;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			scrambled_s2 <= scrambled_d;
			eoc_s2       <= last_s1;
		end
	end

	assign dout.valid           = valid_s2;
	assign dout.scrambled_bits  = scrambled_s2;
	assign dout.end_of_codeword = eoc_s2;

	// a processed word always lands in the output register
	a_move_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> valid_s2)
		else $error("processed word did not reach output register");

	// a first word always leaves x1 running (it never returns to all zero)
	a_x1_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && first_s1) |=> (x1_q != '0))
		else $error("x1 generator not loaded on first word");

	// generators hold while no word is processed
	a_lfsr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!move_s1 |=> ($stable(x1_q) && $stable(x2_q)))
		else $error("generator state moved without a processed word");

	// an empty input register never blocks the input side
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> din.ready)
		else $error("input held off with empty input register");

endmodule
